[rtl/utf8_validating_decoder_top_macros.svh]
// Assertion macros used by the decode module of the UTF-8 decoder.
`ifndef UTF8_VALIDATING_DECODER_TOP_MACROS_SVH
`define UTF8_VALIDATING_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utf8vd_pkg.sv]
// Types, byte range constants and helper function of the UTF-8 decoder.
package utf8vd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        char_valid;
        logic        frame_done;
        logic        status;
        logic [30:0] error_position;
    } result_t;

    localparam logic [2:0] CLS_ANY = 3'd0;
    localparam logic [2:0] CLS_E0  = 3'd1;
    localparam logic [2:0] CLS_ED  = 3'd2;
    localparam logic [2:0] CLS_F0  = 3'd3;
    localparam logic [2:0] CLS_F4  = 3'd4;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;

    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] CONT_8F   = 8'h8F;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_9F   = 8'h9F;
    localparam logic [7:0] CONT_A0   = 8'hA0;

    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;
    localparam logic [20:0] CP_MAX  = 21'h10_FFFF;

    function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] cls);
        logic ok;
        case (cls)
            CLS_E0: ok = b inside {[CONT_A0:CONT_MAX]};
            CLS_ED: ok = b inside {[CONT_MIN:CONT_9F]};
            CLS_F0: ok = b inside {[CONT_90:CONT_MAX]};
            CLS_F4: ok = b inside {[CONT_MIN:CONT_8F]};
            default: ok = b inside {[CONT_MIN:CONT_MAX]};
        endcase
        return ok;
    endfunction

endpackage

[rtl/utf8vd_if.sv]
// Channel interfaces of the UTF-8 decoder: byte input, result output, configuration.
interface utf8vd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8vd_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        char_valid;
    logic        frame_done;
    logic        status;
    logic [30:0] error_position;

    modport source (output valid, output code_point, output char_valid,
                    output frame_done, output status, output error_position, input ready);
    modport sink (input valid, input code_point, input char_valid,
                  input frame_done, input status, input error_position, output ready);
endinterface

interface utf8vd_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] position_base;

    modport source (output valid, output position_base, input ready);
    modport sink (input valid, input position_base, output ready);
endinterface

[rtl/utf8vd_in_stage.sv]
// Input register that holds one accepted byte word until the decoder takes it.
module utf8vd_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    utf8vd_byte_if.sink          byte_ch,
    input  logic                 take,
    output logic                 item_valid,
    output utf8vd_pkg::byte_t    item
);

    logic              valid_reg;
    utf8vd_pkg::byte_t item_reg;
    logic              accept;

    assign byte_ch.ready = !valid_reg || take;
    assign accept        = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= byte_ch.data_byte;
            item_reg.last_byte <= byte_ch.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/utf8vd_decode.sv]
// Decoder state, position base register and the combinational decode of one byte.
`include "utf8_validating_decoder_top_macros.svh"

module utf8vd_decode #(
    parameter int INDEX_WIDTH = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    utf8vd_cfg_if.sink           cfg_ch,
    input  logic                 item_valid,
    input  utf8vd_pkg::byte_t    item,
    input  logic                 out_free,
    output logic                 take,
    output logic                 res_load,
    output utf8vd_pkg::result_t  res
);

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

    logic [30:0]            base_reg;
    logic [1:0]             pending_reg, pending_next;
    logic [20:0]            partial_reg, partial_next;
    logic [2:0]             cls_reg, cls_next;
    logic [INDEX_WIDTH-1:0] index_reg, index_next;
    logic [INDEX_WIDTH-1:0] start_reg, start_next;
    logic                   discard_reg, discard_next;

    logic                   err;
    logic                   emit;
    logic                   frame_end;
    logic [20:0]            cont_word;
    logic [1:0]             pending_dec;
    logic [INDEX_WIDTH-1:0] seq_eff;
    logic [31:0]            epos_sum;
    logic [30:0]            epos_sat;
    logic [7:0]             b;
    logic                   last;

    assign cfg_ch.ready = 1'b1;
    assign take         = item_valid && out_free;
    assign res_load     = take && emit;

    assign b        = item.data_byte;
    assign last     = item.last_byte;
    assign seq_eff  = (pending_reg == 2'd0) ? index_reg : start_reg;
    assign epos_sum = {1'b0, base_reg} + 32'(seq_eff);
    assign epos_sat = epos_sum[31] ? utf8vd_pkg::POS_MAX : epos_sum[30:0];

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        cls_next     = cls_reg;
        index_next   = (index_reg != IDX_MAX) ? index_reg + 1'b1 : index_reg;
        start_next   = start_reg;
        discard_next = discard_reg;
        err          = 1'b0;
        emit         = 1'b0;
        frame_end    = 1'b0;
        res          = '0;
        cont_word    = {partial_reg[14:0], b[5:0]};
        pending_dec  = pending_reg - 2'd1;

        if (discard_reg)
        begin
            frame_end = last;
        end
        else if (pending_reg == 2'd0)
        begin
            start_next = index_reg;
            if (b <= utf8vd_pkg::ASCII_MAX)
            begin
                emit            = 1'b1;
                res.code_point  = 21'(b);
                res.char_valid  = 1'b1;
                res.frame_done  = last;
                frame_end       = last;
            end
            else if (b inside {[utf8vd_pkg::LEAD2_MIN:utf8vd_pkg::LEAD2_MAX]})
            begin
                pending_next = 2'd1;
                partial_next = 21'(b[4:0]);
                cls_next     = utf8vd_pkg::CLS_ANY;
                err          = last;
            end
            else if (b inside {[utf8vd_pkg::LEAD3_MIN:utf8vd_pkg::LEAD3_MAX]})
            begin
                pending_next = 2'd2;
                partial_next = 21'(b[3:0]);
                if (b == utf8vd_pkg::LEAD_E0)
                begin
                    cls_next = utf8vd_pkg::CLS_E0;
                end
                else if (b == utf8vd_pkg::LEAD_ED)
                begin
                    cls_next = utf8vd_pkg::CLS_ED;
                end
                else
                begin
                    cls_next = utf8vd_pkg::CLS_ANY;
                end
                err = last;
            end
            else if (b inside {[utf8vd_pkg::LEAD4_MIN:utf8vd_pkg::LEAD4_MAX]})
            begin
                pending_next = 2'd3;
                partial_next = 21'(b[2:0]);
                if (b == utf8vd_pkg::LEAD_F0)
                begin
                    cls_next = utf8vd_pkg::CLS_F0;
                end
                else if (b == utf8vd_pkg::LEAD_F4)
                begin
                    cls_next = utf8vd_pkg::CLS_F4;
                end
                else
                begin
                    cls_next = utf8vd_pkg::CLS_ANY;
                end
                err = last;
            end
            else
            begin
                err = 1'b1;
            end
        end
        else if (!utf8vd_pkg::cont_ok(b, cls_reg))
        begin
            err = 1'b1;
        end
        else
        begin
            cls_next     = utf8vd_pkg::CLS_ANY;
            pending_next = pending_dec;
            if (pending_dec == 2'd0)
            begin
                emit           = 1'b1;
                res.code_point = cont_word;
                res.char_valid = 1'b1;
                res.frame_done = last;
                partial_next   = '0;
                frame_end      = last;
            end
            else
            begin
                partial_next = cont_word;
                err          = last;
            end
        end

        if (err)
        begin
            emit               = 1'b1;
            res                = '0;
            res.frame_done     = 1'b1;
            res.status         = 1'b1;
            res.error_position = epos_sat;
            if (last)
            begin
                frame_end = 1'b1;
            end
            else
            begin
                pending_next = '0;
                partial_next = '0;
                cls_next     = utf8vd_pkg::CLS_ANY;
                discard_next = 1'b1;
            end
        end

        if (frame_end)
        begin
            index_next   = '0;
            pending_next = '0;
            partial_next = '0;
            cls_next     = utf8vd_pkg::CLS_ANY;
            start_next   = '0;
            discard_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            base_reg <= cfg_ch.position_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            partial_reg <= '0;
            cls_reg     <= utf8vd_pkg::CLS_ANY;
            index_reg   <= '0;
            start_reg   <= '0;
            discard_reg <= 1'b0;
        end
        else if (take)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            cls_reg     <= cls_next;
            index_reg   <= index_next;
            start_reg   <= start_next;
            discard_reg <= discard_next;
        end
    end

    `UVD_ASSERT_NEXT(a_discard_ends, take && discard_reg && last, !discard_reg, "discard mode survived the end of the frame")
    `UVD_ASSERT_NEXT(a_error_discards, res_load && res.status && !last, discard_reg, "an error inside a frame did not start discarding")
    `UVD_ASSERT_SAME(a_idle_when_discarding, discard_reg, pending_reg == 2'd0, "continuation bytes pending while discarding")
    `UVD_ASSERT_SAME(a_scalar_range, res_load && res.char_valid, res.code_point <= utf8vd_pkg::CP_MAX, "decoded code point above the Unicode range")

endmodule

[rtl/utf8vd_out_stage.sv]
// Result register that holds one result word until the consumer takes it.
module utf8vd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    utf8vd_result_if.source      result_ch,
    input  logic                 load,
    input  utf8vd_pkg::result_t  res,
    output logic                 free
);

    logic                valid_reg;
    utf8vd_pkg::result_t res_reg;

    assign free = !valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_ch.valid          = valid_reg;
    assign result_ch.code_point     = res_reg.code_point;
    assign result_ch.char_valid     = res_reg.char_valid;
    assign result_ch.frame_done     = res_reg.frame_done;
    assign result_ch.status         = res_reg.status;
    assign result_ch.error_position = res_reg.error_position;

endmodule

[rtl/utf8_validating_decoder_top.sv]
// Top level of the strict UTF-8 decoder.
// The decoder takes one byte word per clock and turns frames of strict UTF-8 into code
// points; the result of a byte that completes a character or reveals an error is
// registered, and a full throughput of one byte per cycle is held as long as the result
// side takes its words. The rate is set by the combinational decode between the input
// register and the result register, which also updates the sequence state. After an
// error the block reports the saturated sum of the position base and the index of the
// bad sequence's lead byte, then consumes the rest of the frame without results.
module utf8_validating_decoder_top #(
    parameter int INDEX_WIDTH = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    utf8vd_byte_if.sink      byte_ch,
    utf8vd_result_if.source  result_ch,
    utf8vd_cfg_if.sink       cfg_ch
);

    logic                item_valid;
    utf8vd_pkg::byte_t   item;
    logic                take;
    logic                res_load;
    utf8vd_pkg::result_t res;
    logic                out_free;

    utf8vd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    utf8vd_decode #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_ch     (cfg_ch),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    utf8vd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result_ch (result_ch),
        .load      (res_load),
        .res       (res),
        .free      (out_free)
    );

endmodule

[sim/tb_top.sv]
// Testbench of the strict UTF-8 decoder: directed and random framed byte streams checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [30:0] INDEX_MAX = {31{1'b1}};
    localparam logic [7:0] LIMIT_BYTES [10] = '{8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F,
                                                 8'hA0, 8'hBF, 8'hC1, 8'hC2, 8'hF5};

    logic clk;
    logic rst_n;

    utf8vd_byte_if   byte_ch ();
    utf8vd_result_if result_ch ();
    utf8vd_cfg_if    cfg_ch ();

    utf8_validating_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    utf8vd_pkg::byte_t   byte_stream [$];
    utf8vd_pkg::result_t decoded_words [$];
    logic [7:0]  frame_buf [$];
    int          fail_count = 0;
    int          results_seen = 0;

    logic [30:0] base_reg = '0;
    logic [1:0]  pend_cnt = '0;
    logic [20:0] partial = '0;
    logic [2:0]  next_cls = utf8vd_pkg::CLS_ANY;
    logic [30:0] byte_idx = '0;
    logic [30:0] seq_start = '0;
    logic        dropping = 1'b0;

    logic        byte_fire;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic [7:0]  stall_pat = 8'hFF;
    logic [2:0]  pat_pos = '0;
    int          pat_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic cont_allowed(input logic [7:0] b, input logic [2:0] cls);
        case (cls)
            utf8vd_pkg::CLS_E0:
                return b >= utf8vd_pkg::CONT_A0 && b <= utf8vd_pkg::CONT_MAX;
            utf8vd_pkg::CLS_ED:
                return b >= utf8vd_pkg::CONT_MIN && b <= utf8vd_pkg::CONT_9F;
            utf8vd_pkg::CLS_F0:
                return b >= utf8vd_pkg::CONT_90 && b <= utf8vd_pkg::CONT_MAX;
            utf8vd_pkg::CLS_F4:
                return b >= utf8vd_pkg::CONT_MIN && b <= utf8vd_pkg::CONT_8F;
            default:
                return b >= utf8vd_pkg::CONT_MIN && b <= utf8vd_pkg::CONT_MAX;
        endcase
    endfunction

    function automatic void clear_frame();
        byte_idx = '0;
        pend_cnt = '0;
        partial = '0;
        next_cls = utf8vd_pkg::CLS_ANY;
        seq_start = '0;
        dropping = 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [30:0]         pos;
        logic [31:0]         epos;
        utf8vd_pkg::result_t r;
        pos = byte_idx;
        r = '0;
        if (byte_idx != INDEX_MAX)
            byte_idx = byte_idx + 1'b1;
        if (dropping)
        begin
            if (lst)
                clear_frame();
            return;
        end
        if (pend_cnt == 0)
        begin
            seq_start = pos;
            if (b <= utf8vd_pkg::ASCII_MAX)
            begin
                r.code_point = {13'd0, b};
                r.char_valid = 1'b1;
                r.frame_done = lst;
                decoded_words.push_back(r);
                if (lst)
                    clear_frame();
                return;
            end
            if (b >= utf8vd_pkg::LEAD2_MIN && b <= utf8vd_pkg::LEAD4_MAX)
            begin
                if (b <= utf8vd_pkg::LEAD2_MAX)
                begin
                    pend_cnt = 2'd1;
                    partial = {16'd0, b[4:0]};
                    next_cls = utf8vd_pkg::CLS_ANY;
                end
                else if (b <= utf8vd_pkg::LEAD3_MAX)
                begin
                    pend_cnt = 2'd2;
                    partial = {17'd0, b[3:0]};
                    next_cls = (b == utf8vd_pkg::LEAD_E0) ? utf8vd_pkg::CLS_E0 :
                               (b == utf8vd_pkg::LEAD_ED) ? utf8vd_pkg::CLS_ED :
                               utf8vd_pkg::CLS_ANY;
                end
                else
                begin
                    pend_cnt = 2'd3;
                    partial = {18'd0, b[2:0]};
                    next_cls = (b == utf8vd_pkg::LEAD_F0) ? utf8vd_pkg::CLS_F0 :
                               (b == utf8vd_pkg::LEAD_F4) ? utf8vd_pkg::CLS_F4 :
                               utf8vd_pkg::CLS_ANY;
                end
                if (!lst)
                    return;
            end
        end
        else if (cont_allowed(b, next_cls))
        begin
            partial = {partial[14:0], b[5:0]};
            next_cls = utf8vd_pkg::CLS_ANY;
            pend_cnt = pend_cnt - 1'b1;
            if (pend_cnt == 0)
            begin
                r.code_point = partial;
                r.char_valid = 1'b1;
                r.frame_done = lst;
                decoded_words.push_back(r);
                partial = '0;
                if (lst)
                    clear_frame();
                return;
            end
            if (!lst)
                return;
        end
        epos = {1'b0, base_reg} + {1'b0, seq_start};
        r.frame_done = 1'b1;
        r.status = 1'b1;
        r.error_position = (epos > {1'b0, utf8vd_pkg::POS_MAX}) ? utf8vd_pkg::POS_MAX
                                                                 : epos[30:0];
        decoded_words.push_back(r);
        if (lst)
        begin
            clear_frame();
        end
        else
        begin
            pend_cnt = '0;
            partial = '0;
            next_cls = utf8vd_pkg::CLS_ANY;
            dropping = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [30:0] want,
                                        input logic [30:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [20:0] random_scalar();
        case ($urandom_range(0, 9))
            0, 1, 2: return 21'($urandom_range(0, 'h7F));
            3, 4:    return 21'($urandom_range('h80, 'h7FF));
            5, 6, 7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 21'($urandom_range('h800, 'hFFF));
                    1:       return 21'($urandom_range('h1000, 'hCFFF));
                    2:       return 21'($urandom_range('hD000, 'hD7FF));
                    default: return 21'($urandom_range('hE000, 'hFFFF));
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return 21'($urandom_range('h10000, 'h3FFFF));
                    1:       return 21'($urandom_range('h40000, 'hFFFFF));
                    default: return 21'($urandom_range('h100000, 'h10FFFF));
                endcase
            end
        endcase
    endfunction

    function automatic void encode_char(input logic [20:0] cp);
        if (cp < 'h80)
        begin
            frame_buf.push_back(cp[7:0]);
        end
        else if (cp < 'h800)
        begin
            frame_buf.push_back({3'b110, cp[10:6]});
            frame_buf.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 'h10000)
        begin
            frame_buf.push_back({4'b1110, cp[15:12]});
            frame_buf.push_back({2'b10, cp[11:6]});
            frame_buf.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            frame_buf.push_back({5'b11110, cp[20:18]});
            frame_buf.push_back({2'b10, cp[17:12]});
            frame_buf.push_back({2'b10, cp[11:6]});
            frame_buf.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void flush_frame();
        utf8vd_pkg::byte_t item;
        foreach (frame_buf[i])
        begin
            item.data_byte = frame_buf[i];
            item.last_byte = (i == frame_buf.size() - 1);
            byte_stream.push_back(item);
        end
        frame_buf.delete();
    endfunction

    function automatic void directed_frame(input logic [79:0] bytes, input int n);
        frame_buf.delete();
        for (int i = n - 1; i >= 0; i--)
            frame_buf.push_back(bytes[i*8 +: 8]);
        flush_frame();
    endfunction

    function automatic void random_frames(input int n_bytes);
        int added;
        int nch;
        int k;
        int p;
        added = 0;
        while (added < n_bytes)
        begin
            frame_buf.delete();
            if ($urandom_range(0, 19) == 0)
            begin
                nch = $urandom_range(1, 8);
                repeat (nch) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                nch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
                repeat (nch) encode_char(random_scalar());
                if ($urandom_range(0, 3) == 0)
                begin
                    p = $urandom_range(0, frame_buf.size() - 1);
                    case ($urandom_range(0, 2))
                        0: frame_buf[p] = 8'($urandom_range(0, 255));
                        1: frame_buf[p] = LIMIT_BYTES[$urandom_range(0, 9)];
                        default:
                        begin
                            k = $urandom_range(1, 3);
                            while (k > 0 && frame_buf.size() > 1)
                            begin
                                void'(frame_buf.pop_back());
                                k--;
                            end
                        end
                    endcase
                end
            end
            added += frame_buf.size();
            flush_frame();
        end
    endfunction

    task automatic set_base(input logic [30:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.position_base <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        base_reg = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (byte_stream.size() != 0 || decoded_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Byte words are taken off the stream and predicted at the edge that accepts them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_fire <= 1'b0;
        end
        else
        begin
            byte_fire <= byte_ch.valid && byte_ch.ready;
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.data_byte, byte_ch.last_byte);
                void'(byte_stream.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
        end
        else if (byte_ch.valid && !byte_fire)
        begin
        end
        else if (gap_left > 0)
        begin
            byte_ch.valid <= 1'b0;
            gap_left--;
        end
        else if (byte_stream.size() > 0)
        begin
            byte_ch.valid <= 1'b1;
            byte_ch.data_byte <= byte_stream[0].data_byte;
            byte_ch.last_byte <= byte_stream[0].last_byte;
            if (burst_left <= 1)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            byte_ch.valid <= 1'b0;
        end
    end

    // The result side stalls on a changing pattern, once for a long stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && results_seen >= 200)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
                pat_left = $urandom_range(16, 96);
            end
            pat_left--;
            result_ch.ready <= stall_pat[pat_pos];
            pat_pos = pat_pos + 1'b1;
        end
    end

    always @(posedge clk)
    begin
        utf8vd_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (decoded_words.size() == 0)
            begin
                $error("result word with none predicted: code_point %0h status %0b",
                       result_ch.code_point, result_ch.status);
                fail_count++;
            end
            else
            begin
                want = decoded_words.pop_front();
                check_field("code_point", 31'(want.code_point), 31'(result_ch.code_point));
                check_field("char_valid", 31'(want.char_valid), 31'(result_ch.char_valid));
                check_field("frame_done", 31'(want.frame_done), 31'(result_ch.frame_done));
                check_field("status", 31'(want.status), 31'(result_ch.status));
                check_field("error_position", want.error_position, result_ch.error_position);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [30:0] bases [5];
        bases = '{31'h7FFF_FFFF, 31'h7FFF_FFFA, 31'($urandom), 31'd0, 31'd1000};
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.position_base = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        set_base(31'd0);
        directed_frame(80'h7FDFBFE0A080F48FBFBF, 10);
        directed_frame(80'h00C2, 2);
        directed_frame(80'hC1, 1);
        directed_frame(80'hF541, 2);
        directed_frame(80'hEDA0, 2);
        directed_frame(80'hF08F, 2);
        directed_frame(80'hE09F, 2);
        directed_frame(80'hF490, 2);
        directed_frame(80'h80, 1);
        wait_drained();

        foreach (bases[i])
        begin
            set_base(bases[i]);
            random_frames(350);
            wait_drained();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[utf8_validating_decoder_top.f]
+incdir+rtl
rtl/utf8vd_pkg.sv
rtl/utf8vd_if.sv
rtl/utf8vd_in_stage.sv
rtl/utf8vd_decode.sv
rtl/utf8vd_out_stage.sv
rtl/utf8_validating_decoder_top.sv
sim/tb_top.sv
